// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl, clocked on clk, disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== hdl/mots_pkg.sv =====
// ----------------------------------------------------------------------------
// mots_pkg
// Constants for the most overdue task scheduler: widths, operation codes,
// register count and period reset values.
// ----------------------------------------------------------------------------
package mots_pkg;

    localparam int TIME_W        = 32;
    localparam int SLOT_W        = 3;
    localparam int REG_COUNT     = 6;
    localparam int REG_IDX_W     = 3;
    localparam int NUM_SLOTS_DEF = 6;

    // a slot must be late by more than this to run
    localparam logic [TIME_W-1:0] MIN_DELAY = 32'd1;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic [TIME_W-1:0] PERIOD_RESET [REG_COUNT] = '{
        32'd20000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3500
    };

endpackage

// ===== hdl/most_overdue_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// most_overdue_task_scheduler
// Picks the most overdue of the task slots on each tick and reschedules it.
// ----------------------------------------------------------------------------
// During a tick one adder walks the stored planned times one slot per cycle,
// computing now - planned and comparing it with the best delay so far, and the
// same adder then forms now + period for the write-back in the finish state.
// A trigger clears the planned time of the named slot, if in range, and gives
// an empty result. in_ready is high only while the sequencer is idle; a
// finished result sits in the output register and a new item can be taken
// while it waits. Ties go to the lowest slot index; a slot runs only if its
// delay is at least 2.
`include "assert_macros.svh"

module most_overdue_task_scheduler #(
    parameter int NUM_SLOTS = mots_pkg::NUM_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [mots_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [mots_pkg::TIME_W-1:0]    cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [mots_pkg::TIME_W-1:0]    now_time,
    input  logic [mots_pkg::SLOT_W-1:0]    slot_index,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ran,
    output logic [mots_pkg::SLOT_W-1:0]    chosen_slot,
    output logic [mots_pkg::TIME_W-1:0]    next_due
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TW    = mots_pkg::TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [TW-1:0]       period_reg [mots_pkg::REG_COUNT];
    logic [TW-1:0]       planned_reg [NUM_SLOTS];
    logic [TW-1:0]       now_reg;
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [TW-1:0]       best_delay_reg;
    logic                found_reg;
    logic                out_valid_reg;
    logic                ran_reg;
    logic [mots_pkg::SLOT_W-1:0] chosen_reg;
    logic [TW-1:0]       next_due_reg;

    logic                in_xfer;
    logic                out_free;
    logic                scanning;
    logic [TW-1:0]       operand_b;
    logic [TW-1:0]       sum;
    logic                trig_hit;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign scanning = (state_reg == ST_SCAN);
    assign trig_hit = (32'(slot_index) < 32'(NUM_SLOTS));

    // shared adder: now - planned while scanning, now + period on write-back
    assign operand_b = scanning ? ~planned_reg[scan_idx_reg]
                                : period_reg[mots_pkg::REG_IDX_W'(best_idx_reg)];
    assign sum = now_reg + operand_b + TW'(scanning);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (operation == mots_pkg::OP_TICK) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            for (int k = 0; k < mots_pkg::REG_COUNT; k++)
            begin
                period_reg[k] <= mots_pkg::PERIOD_RESET[k];
            end
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                planned_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we && (32'(cfg_index) < 32'(mots_pkg::REG_COUNT)))
            begin
                period_reg[cfg_index] <= cfg_data;
            end

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        found_reg <= 1'b0;
                        if ((operation == mots_pkg::OP_TRIGGER) && trig_hit)
                        begin
                            planned_reg[slot_index[IDX_W-1:0]] <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (sum > best_delay_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        if (found_reg)
                        begin
                            planned_reg[best_idx_reg] <= sum;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            now_reg        <= now_time;
            scan_idx_reg   <= '0;
            best_idx_reg   <= '0;
            best_delay_reg <= mots_pkg::MIN_DELAY;
        end
        else if (scanning)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (sum > best_delay_reg)
            begin
                best_delay_reg <= sum;
                best_idx_reg   <= scan_idx_reg;
            end
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            ran_reg      <= found_reg;
            chosen_reg   <= found_reg ? mots_pkg::SLOT_W'(best_idx_reg) : '0;
            next_due_reg <= found_reg ? sum : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ran         = ran_reg;
    assign chosen_slot = chosen_reg;
    assign next_due    = next_due_reg;

    `CHK_NEXT(a_tick_starts_scan, in_xfer && (operation == mots_pkg::OP_TICK), state_reg == ST_SCAN, "tick did not start a scan")
    `CHK_IMPLY(a_found_is_late, found_reg && (state_reg == ST_FINISH), best_delay_reg > mots_pkg::MIN_DELAY, "chosen slot not overdue")
    `CHK_IMPLY(a_chosen_in_range, out_valid && ran, 32'(chosen_slot) < 32'(NUM_SLOTS), "chosen slot out of range")
    `CHK_IMPLY(a_idle_result_zero, out_valid && !ran, (chosen_slot == '0) && (next_due == '0), "empty result not zero")

endmodule
